// ----- hw/rtl/glpf_pkg.sv -----
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared widths, codes and types of the grid local peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  // Neighbour presence and line RAM selection of one decision
  typedef struct packed {
    logic has_up;
    logic has_left;
    logic has_right;
    logic has_below;
    logic parity;     // RAM that holds the row above and takes the write
  } flags_t;

endpackage

// ----- hw/rtl/glpf_line_ram.sv -----
// ----------------------------------------------------------------------------
// glpf_line_ram
// One row buffer: one write and one registered read per cycle, read-first.
// ----------------------------------------------------------------------------
module glpf_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [ADDR_W-1:0]            waddr_i,
  input  logic [glpf_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [ADDR_W-1:0]            raddr_i,
  output logic [glpf_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [glpf_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [glpf_pkg::SAMPLE_W-1:0] rdata_q;

  // A read of the entry being written returns the old contents
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/glpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// glpf_ctrl
// Grid registers, raster position counters and line RAM address generation.
// ----------------------------------------------------------------------------
module glpf_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COL_W      = 10,
  parameter int ROW_W      = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [glpf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [glpf_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             in_mode_i,
  input  logic [glpf_pkg::SAMPLE_W-1:0]    in_sample_i,
  output logic [1:0]                       ram_we_o,
  output logic [COL_W-1:0]                 ram_waddr_o,
  output logic [glpf_pkg::SAMPLE_W-1:0]    ram_wdata_o,
  output logic [1:0]                       ram_re_o,
  output logic [1:0][COL_W-1:0]            ram_raddr_o,
  output logic                             op_valid_o,
  output glpf_pkg::flags_t                 op_flags_o,
  output logic [ROW_W-1:0]                 op_row_o,
  output logic [COL_W-1:0]                 op_col_o,
  output logic [glpf_pkg::SAMPLE_W-1:0]    op_below_o,
  output logic [glpf_pkg::SAMPLE_W-1:0]    op_cur0_o
);

  localparam int WCW = ($clog2(MAX_WIDTH + 1) > glpf_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : glpf_pkg::CFG_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > glpf_pkg::CFG_W) ?
                       $clog2(MAX_HEIGHT + 1) : glpf_pkg::CFG_W;

  logic [COL_W-1:0] last_col_q, last_col_d;
  logic [ROW_W-1:0] last_row_q, last_row_d;
  logic [COL_W-1:0] ac_q, ac_d;
  logic [ROW_W-1:0] ar_q, ar_d;
  logic             flush_q, flush_d;
  logic [glpf_pkg::SAMPLE_W-1:0] col0_q;

  logic             accept, is_flush, do_flush, do_sample, decide, par;
  logic [COL_W-1:0] col_nxt;
  logic [WCW-1:0]   w_ext, w_lim;
  logic [HCW-1:0]   h_ext, h_lim;

  // Clamp the written sizes and keep them as the last column and row index
  always_comb begin
    w_ext = WCW'(cfg_wdata_i);
    h_ext = HCW'(cfg_wdata_i);
    if (w_ext < WCW'(2)) begin
      w_lim = WCW'(2);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_lim = WCW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext < HCW'(2)) begin
      h_lim = HCW'(2);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      h_lim = HCW'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
  end

  assign accept    = in_valid_i && !in_stall_i;
  assign is_flush  = (in_mode_i == glpf_pkg::MODE_FLUSH);
  assign do_flush  = accept && is_flush && flush_q;
  assign do_sample = accept && !is_flush && !flush_q;
  assign decide    = do_flush || (do_sample && (ar_q != '0));
  // During the flush the row above the last row sits in the other RAM
  assign par       = flush_q ? ~last_row_q[0] : ar_q[0];
  assign col_nxt   = ac_q + 1'b1;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ram_raddr_o[i] = (par == 1'(i)) ? ac_q : col_nxt;
      ram_we_o[i]    = do_sample && (ar_q[0] == 1'(i));
    end
  end

  assign ram_re_o    = {2{decide}};
  assign ram_waddr_o = ac_q;
  assign ram_wdata_o = in_sample_i;

  assign op_valid_o           = decide;
  assign op_flags_o.has_up    = flush_q || (ar_q != ROW_W'(1));
  assign op_flags_o.has_left  = (ac_q != '0);
  assign op_flags_o.has_right = (ac_q != last_col_q);
  assign op_flags_o.has_below = !flush_q;
  assign op_flags_o.parity    = par;
  assign op_row_o             = flush_q ? last_row_q : ar_q - 1'b1;
  assign op_col_o             = ac_q;
  assign op_below_o           = in_sample_i;
  assign op_cur0_o            = col0_q;

  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    ac_d       = ac_q;
    ar_d       = ar_q;
    flush_d    = flush_q;
    priority if (cfg_we_i) begin
      unique case (cfg_addr_i)
        glpf_pkg::REG_GRID_WIDTH:  last_col_d = COL_W'(w_lim - 1'b1);
        glpf_pkg::REG_GRID_HEIGHT: last_row_d = ROW_W'(h_lim - 1'b1);
        default:                   last_col_d = last_col_q;
      endcase
      // Restart the frame
      ac_d    = '0;
      ar_d    = '0;
      flush_d = 1'b0;
    end else if (do_sample) begin
      if (ac_q == last_col_q) begin
        ac_d = '0;
        if (ar_q == last_row_q) begin
          ar_d    = '0;
          flush_d = 1'b1;
        end else begin
          ar_d = ar_q + 1'b1;
        end
      end else begin
        ac_d = col_nxt;
      end
    end else if (do_flush) begin
      if (ac_q == last_col_q) begin
        ac_d    = '0;
        flush_d = 1'b0;
      end else begin
        ac_d = col_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= COL_W'(1);
      last_row_q <= ROW_W'(1);
      ac_q       <= '0;
      ar_q       <= '0;
      flush_q    <= 1'b0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      ac_q       <= ac_d;
      ar_q       <= ar_d;
      flush_q    <= flush_d;
    end
  end

  // Hold the first sample of the latest row for the next row's column 0
  always_ff @(posedge clk_i) begin
    if (do_sample && (ac_q == '0)) begin
      col0_q <= in_sample_i;
    end
  end

`ifndef ASSERT_OFF
  a_flush_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (ar_q == '0))
    else $error("flush in progress with a non-zero row counter");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ac_q <= last_col_q)
    else $error("column counter beyond the last column");

  a_write_read_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && (ram_we_o != 2'b00)) |-> (ram_raddr_o[ar_q[0]] == ram_waddr_o))
    else $error("row above not read from the entry being overwritten");
`endif

endmodule

// ----- hw/rtl/glpf_decide.sv -----
// ----------------------------------------------------------------------------
// glpf_decide
// Neighbour window, four-way compare and result register.
// ----------------------------------------------------------------------------
module glpf_decide #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 op_valid_i,
  input  glpf_pkg::flags_t                     op_flags_i,
  input  logic [ROW_W-1:0]                     op_row_i,
  input  logic [COL_W-1:0]                     op_col_i,
  input  logic [glpf_pkg::SAMPLE_W-1:0]        op_below_i,
  input  logic [glpf_pkg::SAMPLE_W-1:0]        op_cur0_i,
  input  logic [1:0][glpf_pkg::SAMPLE_W-1:0]   rd_data_i,
  input  logic                                 out_stall_i,
  output logic                                 busy_o,
  output logic                                 out_valid_o,
  output logic [glpf_pkg::PEAK_W-1:0]          out_peak_row_o,
  output logic [glpf_pkg::PEAK_W-1:0]          out_peak_col_o
);

  logic                          s1_valid_q, s1_valid_d;
  glpf_pkg::flags_t              s1_flags_q;
  logic [ROW_W-1:0]              s1_row_q;
  logic [COL_W-1:0]              s1_col_q;
  logic [glpf_pkg::SAMPLE_W-1:0] s1_below_q, s1_cur0_q;
  logic [glpf_pkg::SAMPLE_W-1:0] win_cur_q, win_right_q;
  logic                          out_valid_q, out_valid_d;
  logic [glpf_pkg::PEAK_W-1:0]   row_q, col_q;

  logic                          out_hold, fire, peak;
  logic signed [glpf_pkg::SAMPLE_W-1:0] cur, above, left, right, below;

  assign out_hold = out_valid_q && out_stall_i;
  assign fire     = s1_valid_q && !out_hold;
  assign busy_o   = s1_valid_q && out_hold;

  // The previous decision's right neighbour is this one's centre
  assign above = rd_data_i[s1_flags_q.parity];
  assign right = rd_data_i[~s1_flags_q.parity];
  assign cur   = s1_flags_q.has_left ? win_right_q : s1_cur0_q;
  assign left  = win_cur_q;
  assign below = s1_below_q;

  assign peak = (!s1_flags_q.has_up    || (cur >= above)) &&
                (!s1_flags_q.has_left  || (cur >= left))  &&
                (!s1_flags_q.has_right || (cur >= right)) &&
                (!s1_flags_q.has_below || (cur >= below));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (op_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = peak;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i) begin
      s1_flags_q <= op_flags_i;
      s1_row_q   <= op_row_i;
      s1_col_q   <= op_col_i;
      s1_below_q <= op_below_i;
      s1_cur0_q  <= op_cur0_i;
    end
    if (fire) begin
      win_cur_q   <= cur;
      win_right_q <= right;
      row_q       <= glpf_pkg::PEAK_W'(s1_row_q);
      col_q       <= glpf_pkg::PEAK_W'(s1_col_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_peak_row_o = row_q;
  assign out_peak_col_o = col_q;

`ifndef ASSERT_OFF
  a_hold_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("pending decision dropped while the result was stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i |-> !busy_o)
    else $error("new decision issued while the stage was held");

  a_left_matches_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_flags_q.has_left == (s1_col_q != '0)))
    else $error("left neighbour flag disagrees with the column");
`endif

endmodule

// ----- hw/rtl/grid_local_peak_finder.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// Four-neighbour local maxima of a raster-order grid of signed samples.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless in_stall_o is high, samples and flush
// ticks alike, and returns the row and column of each local maximum through
// the s1 stage and result registers (a cell is decided by the sample below
// it, or on the last row by the flush ticks that follow the frame). The rate
// is set by the two line RAMs of MAX_WIDTH x 16 bits, one per row parity: one
// RAM is read at the current column (the row above) and written with the new
// sample, the other is read one column ahead (the right neighbour), and the
// centre and left values slide through registers. The RAMs need no clearing
// pass after reset. Writing grid_width or grid_height restarts the frame.
// ----------------------------------------------------------------------------
module grid_local_peak_finder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [glpf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [glpf_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_mode_i,
  input  logic [glpf_pkg::SAMPLE_W-1:0]    in_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [glpf_pkg::PEAK_W-1:0]      out_peak_row_o,
  output logic [glpf_pkg::PEAK_W-1:0]      out_peak_col_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [1:0]                              ram_we, ram_re;
  logic [COL_W-1:0]                        ram_waddr;
  logic [glpf_pkg::SAMPLE_W-1:0]           ram_wdata;
  logic [1:0][COL_W-1:0]                   ram_raddr;
  logic [1:0][glpf_pkg::SAMPLE_W-1:0]      ram_rdata;
  logic                                    op_valid, busy;
  glpf_pkg::flags_t                        op_flags;
  logic [ROW_W-1:0]                        op_row;
  logic [COL_W-1:0]                        op_col;
  logic [glpf_pkg::SAMPLE_W-1:0]           op_below, op_cur0;

  assign in_stall_o = busy;

  glpf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (busy),
    .in_mode_i   (in_mode_i),
    .in_sample_i (in_sample_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .op_valid_o  (op_valid),
    .op_flags_o  (op_flags),
    .op_row_o    (op_row),
    .op_col_o    (op_col),
    .op_below_o  (op_below),
    .op_cur0_o   (op_cur0)
  );

  for (genvar i = 0; i < 2; i++) begin : g_line
    glpf_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[i]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .re_i    (ram_re[i]),
      .raddr_i (ram_raddr[i]),
      .rdata_o (ram_rdata[i])
    );
  end

  glpf_decide #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_decide (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_flags_i     (op_flags),
    .op_row_i       (op_row),
    .op_col_i       (op_col),
    .op_below_i     (op_below),
    .op_cur0_i      (op_cur0),
    .rd_data_i      (ram_rdata),
    .out_stall_i    (out_stall_i),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_peak_row_o (out_peak_row_o),
    .out_peak_col_o (out_peak_col_o)
  );

endmodule

// ----- sim/grid_local_peak_finder_tb.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_finder_tb
// Self-checking bench for the four-neighbour grid peak finder.
// ----------------------------------------------------------------------------
// A clocked driver feeds samples and flush ticks from a queue. On each
// accepted transaction a local line-buffer predictor queues the peak it
// expects. A clocked monitor compares each peak leaving the block, row and
// column, against that queue. Frames of many sizes are sent, with ties,
// plateaus, extreme values, ignored ticks, cut-short frames, random sender
// gaps and receiver stalls, one long output hold, and a cut frame at the
// widest size.
// ----------------------------------------------------------------------------
module grid_local_peak_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SAMPLE_W      = glpf_pkg::SAMPLE_W;
  localparam int          PEAK_W        = glpf_pkg::PEAK_W;
  localparam int          CFG_W         = glpf_pkg::CFG_W;
  localparam int          CFG_ADDR_W    = glpf_pkg::CFG_ADDR_W;
  localparam int          MAX_W         = 1024;
  localparam int          MAX_H         = 1024;
  localparam int          RANDOM_ITEMS  = 600;
  localparam int          WIDE_TAIL     = 96;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 400;
  localparam int unsigned FULL_SAMPLE   = 65535;

  typedef enum int {KIND_FULL, KIND_NARROW, KIND_PLATEAU, KIND_EXTREME} frame_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } grid_item_t;

  typedef struct {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
  } peak_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i     = glpf_pkg::REG_GRID_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  in_mode_i      = glpf_pkg::MODE_SAMPLE;
  logic [SAMPLE_W-1:0]   in_sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [PEAK_W-1:0]     out_peak_row_o;
  logic [PEAK_W-1:0]     out_peak_col_o;

  grid_local_peak_finder #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_mode_i      (in_mode_i),
    .in_sample_i    (in_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_peak_row_o (out_peak_row_o),
    .out_peak_col_o (out_peak_col_o)
  );

  grid_item_t  grid_item_q[$];
  peak_t       peak_q[$];
  peak_t       head_pk;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_done  = 1'b0;
  int unsigned hold_left       = 0;

  int unsigned errors        = 0;
  int unsigned accepted_txns = 0;
  int unsigned peaks_checked = 0;
  int unsigned stim_items    = 0;
  int unsigned frames_sent   = 0;

  // Predictor state: raw registers, arrival position, owed flush ticks, rows
  logic [CFG_W-1:0]           cols_reg   = 11'd2;
  logic [CFG_W-1:0]           rows_reg   = 11'd2;
  int unsigned                next_row   = 0;
  int unsigned                next_col   = 0;
  int unsigned                flush_owed = 0;
  logic signed [SAMPLE_W-1:0] row_buf [2*MAX_W];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] raw, int unsigned hi);
    if (raw < 2) return 2;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int unsigned slot_of(int unsigned r, int unsigned c);
    return ((r & 1) * MAX_W + c) % (2 * MAX_W);
  endfunction

  function automatic void restart_frame();
    next_row   = 0;
    next_col   = 0;
    flush_owed = 0;
  endfunction

  function automatic bit cell_is_peak(int unsigned r, int unsigned c, int unsigned cols,
                                      logic signed [SAMPLE_W-1:0] above, bit has_below,
                                      logic signed [SAMPLE_W-1:0] below);
    logic signed [SAMPLE_W-1:0] centre;
    centre = row_buf[slot_of(r, c)];
    if (r > 0 && centre < above) return 1'b0;
    if (c > 0 && centre < row_buf[slot_of(r, c - 1)]) return 1'b0;
    if (c + 1 < cols && centre < row_buf[slot_of(r, c + 1)]) return 1'b0;
    if (has_below && centre < below) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the grid model by one transaction and queue the peak it decides
  function automatic void predict_peak(logic mode, logic [SAMPLE_W-1:0] raw);
    int unsigned                cols;
    int unsigned                rows;
    int unsigned                r;
    int unsigned                c;
    logic signed [SAMPLE_W-1:0] value;
    peak_t                      pk;
    cols  = clamp_dim(cols_reg, MAX_W);
    rows  = clamp_dim(rows_reg, MAX_H);
    value = raw;
    if (mode == glpf_pkg::MODE_FLUSH) begin
      if (flush_owed == 0) return;
      r = rows - 1;
      c = cols - flush_owed;
      if (cell_is_peak(r, c, cols, row_buf[slot_of(r - 1, c)], 1'b0, '0)) begin
        pk.row = r[PEAK_W-1:0];
        pk.col = c[PEAK_W-1:0];
        peak_q.push_back(pk);
      end
      flush_owed--;
      if (flush_owed == 0) restart_frame();
      return;
    end
    // drop samples while the last row is still being flushed
    if (flush_owed != 0) return;
    if (next_row > 0) begin
      r = next_row - 1;
      if (cell_is_peak(r, next_col, cols, row_buf[slot_of(next_row, next_col)], 1'b1,
                       value)) begin
        pk.row = r[PEAK_W-1:0];
        pk.col = next_col[PEAK_W-1:0];
        peak_q.push_back(pk);
      end
    end
    row_buf[slot_of(next_row, next_col)] = value;
    next_col++;
    if (next_col >= cols) begin
      next_col = 0;
      next_row++;
      if (next_row >= rows) begin
        next_row   = 0;
        flush_owed = cols;
      end
    end
  endfunction

  // Driver: hold the payload while stalled, otherwise load the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_peak(in_mode_i, in_sample_i);
        accepted_txns++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (grid_item_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i  <= 1'b1;
          in_mode_i   <= grid_item_q[0].mode;
          in_sample_i <= grid_item_q[0].sample;
          void'(grid_item_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each peak transaction, and drive the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (peak_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected peak, expected none, got row %0d col %0d",
                   $time, out_peak_row_o, out_peak_col_o);
        end else begin
          head_pk = peak_q.pop_front();
          peaks_checked++;
          if (out_peak_row_o !== head_pk.row) begin
            errors++;
            $display("%0t: peak row mismatch, expected %0d, got %0d",
                     $time, head_pk.row, out_peak_row_o);
          end
          if (out_peak_col_o !== head_pk.col) begin
            errors++;
            $display("%0t: peak col mismatch, expected %0d, got %0d",
                     $time, head_pk.col, out_peak_col_o);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
        out_stall_i    <= 1'b1;
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  function automatic void push_item(logic mode, logic [SAMPLE_W-1:0] sample);
    grid_item_t it;
    it.mode   = mode;
    it.sample = sample;
    grid_item_q.push_back(it);
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample(frame_kind_e kind,
                                                      logic [SAMPLE_W-1:0] level);
    int tmp;
    unique case (kind)
      KIND_NARROW: begin
        tmp = int'($urandom_range(0, 4)) - 2;
        return tmp[SAMPLE_W-1:0];
      end
      KIND_PLATEAU: return level;
      KIND_EXTREME: begin
        unique case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(0, FULL_SAMPLE));
    endcase
  endfunction

  // Queue one frame: samples then flush ticks, or only the first cut samples
  function automatic void queue_frame(int unsigned cols, int unsigned rows,
                                      frame_kind_e kind, bit noisy, int unsigned cut);
    int unsigned         n_samples;
    logic [SAMPLE_W-1:0] level;
    level     = SAMPLE_W'($urandom_range(0, FULL_SAMPLE));
    n_samples = (cut != 0) ? cut : cols * rows;
    for (int unsigned i = 0; i < n_samples; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        push_item(glpf_pkg::MODE_FLUSH, SAMPLE_W'($urandom_range(0, FULL_SAMPLE)));
      push_item(glpf_pkg::MODE_SAMPLE, next_sample(kind, level));
      stim_items++;
    end
    if (cut == 0) begin
      for (int unsigned i = 0; i < cols; i++) begin
        if (noisy && $urandom_range(0, 15) == 0)
          push_item(glpf_pkg::MODE_SAMPLE, SAMPLE_W'($urandom_range(0, FULL_SAMPLE)));
        push_item(glpf_pkg::MODE_FLUSH, SAMPLE_W'($urandom_range(0, FULL_SAMPLE)));
        stim_items++;
      end
      frames_sent++;
    end
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    if (idx == glpf_pkg::REG_GRID_WIDTH) cols_reg = value;
    else rows_reg = value;
    restart_frame();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (grid_item_q.size() != 0 || in_valid_i || peak_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_idling(idle_mode_e m);
    unique case (m)
      IDLE_SEND: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
      IDLE_RECV: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
      IDLE_BOTH: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      default:   begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 1));
    return CFG_W'($urandom_range(2, 12));
  endfunction

  initial begin
    int unsigned start_items;
    int unsigned phase;
    int unsigned nframes;
    int unsigned cols;
    int unsigned rows;
    int unsigned cut;
    frame_kind_e kind;

    for (int i = 0; i < 2 * MAX_W; i++) row_buf[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray flush, corner extremes, a sample amid flush ticks, a plateau
    set_idling(IDLE_NONE);
    write_reg(glpf_pkg::REG_GRID_WIDTH, 11'd2);
    write_reg(glpf_pkg::REG_GRID_HEIGHT, 11'd2);
    push_item(glpf_pkg::MODE_FLUSH, 16'h0000);
    push_item(glpf_pkg::MODE_SAMPLE, 16'h7FFF);
    push_item(glpf_pkg::MODE_SAMPLE, 16'h8000);
    push_item(glpf_pkg::MODE_SAMPLE, 16'h8000);
    push_item(glpf_pkg::MODE_SAMPLE, 16'h7FFF);
    push_item(glpf_pkg::MODE_FLUSH, 16'hFFFF);
    push_item(glpf_pkg::MODE_SAMPLE, 16'h1234);
    push_item(glpf_pkg::MODE_FLUSH, 16'h0000);
    stim_items += 6;
    frames_sent++;
    wait_idle();
    write_reg(glpf_pkg::REG_GRID_WIDTH, 11'd3);
    write_reg(glpf_pkg::REG_GRID_HEIGHT, 11'd3);
    queue_frame(3, 3, KIND_PLATEAU, 1'b0, 0);
    wait_idle();

    // Random phases of small grids, cycling through the idling mixes
    start_items = stim_items;
    phase       = 0;
    while (phase < 4 || stim_items - start_items < RANDOM_ITEMS) begin
      if (phase == 2) begin
        write_reg(glpf_pkg::REG_GRID_WIDTH, 11'd10);
        write_reg(glpf_pkg::REG_GRID_HEIGHT, 11'd8);
      end else begin
        unique case ($urandom_range(0, 3))
          0: write_reg(glpf_pkg::REG_GRID_WIDTH, pick_dim());
          1: write_reg(glpf_pkg::REG_GRID_HEIGHT, pick_dim());
          default: begin
            write_reg(glpf_pkg::REG_GRID_WIDTH, pick_dim());
            write_reg(glpf_pkg::REG_GRID_HEIGHT, pick_dim());
          end
        endcase
      end
      set_idling(idle_mode_e'(phase % 4));
      // hold the output off while a dense frame keeps arriving
      if (phase == 2) long_hold_req = 1'b1;
      cols    = clamp_dim(cols_reg, MAX_W);
      rows    = clamp_dim(rows_reg, MAX_H);
      nframes = $urandom_range(1, 3);
      for (int unsigned f = 0; f < nframes; f++) begin
        kind = (phase == 2 && f == 0) ? KIND_PLATEAU : frame_kind_e'($urandom_range(0, 3));
        cut  = 0;
        if (f == nframes - 1 && $urandom_range(0, 6) == 0)
          cut = $urandom_range(1, cols * rows - 1);
        queue_frame(cols, rows, kind, $urandom_range(0, 3) == 0, cut);
      end
      wait_idle();
      phase++;
    end

    // Widest size, reached through out-of-range register values, cut early in row 1
    set_idling(IDLE_SEND);
    write_reg(glpf_pkg::REG_GRID_WIDTH, 11'd2047);
    write_reg(glpf_pkg::REG_GRID_HEIGHT, 11'd2047);
    queue_frame(MAX_W, MAX_H, KIND_FULL, 1'b0, MAX_W + WIDE_TAIL);
    wait_idle();

    if (peak_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected peaks never arrived", $time, peak_q.size());
    end
    $display("summary: %0d transactions accepted, %0d peaks checked, %0d full frames",
             accepted_txns, peaks_checked, frames_sent);
    $display("summary: grids up to 12x12 and a cut frame 1024 wide, ties and plateaus, %s",
             "ignored ticks, cut frames, gaps, stalls and one long hold");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timed out", $time);
    $display("tb: failure");
    $finish;
  end

endmodule
